FILE: rtl/core/rk4msd_pkg.sv
// ----------------------------------------------------------------------------
// rk4msd_pkg
// Shared types, control-store layout and microprogram for the RK4
// mass-spring-damper step engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rk4msd_pkg;

  localparam int PC_W     = 6;
  localparam int RF_DEPTH = 16;

  typedef enum logic [1:0] {
    CFG_TIME_STEP    = 2'd0,
    CFG_DAMPING      = 2'd1,
    CFG_STIFFNESS    = 2'd2,
    CFG_INVERSE_MASS = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_READ,
    SQ_EXEC,
    SQ_WAIT,
    SQ_OUT
  } seq_state_t;

  typedef enum logic [2:0] {
    MS_IDLE,
    MS_MUL,
    MS_DIV,
    MS_FIN,
    MS_NEG
  } mul_state_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_END
  } uop_t;

  typedef enum logic [3:0] {
    R_X,
    R_V,
    R_U,
    R_T,
    R_S,
    R_A1,
    R_A2,
    R_A3,
    R_A4,
    R_V2,
    R_V3,
    R_V4,
    R_XA,
    R_SX,
    R_SV
  } reg_id_t;

  typedef enum logic [1:0] {
    C_TS,
    C_DAMP,
    C_STIFF,
    C_IMASS
  } coef_t;

  // half: extra right shift by one; div6: divide by three, then extra shift
  typedef struct packed {
    logic half;
    logic div6;
  } mul_ctl_t;

  typedef struct packed {
    uop_t     op;
    reg_id_t  dst;
    reg_id_t  src_a;
    reg_id_t  src_b;
    coef_t    coef;
    mul_ctl_t mctl;
  } uword_t;

  function automatic uword_t uw(input uop_t op, input reg_id_t dst, input reg_id_t src_a,
                                input reg_id_t src_b, input coef_t coef, input logic half,
                                input logic div6);
    uword_t w;
    w.op        = op;
    w.dst       = dst;
    w.src_a     = src_a;
    w.src_b     = src_b;
    w.coef      = coef;
    w.mctl.half = half;
    w.mctl.div6 = div6;
    return w;
  endfunction

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      // slope 1
      6'd0:  w = uw(OP_MUL, R_T,  R_V,  R_V,  C_DAMP,  1'b0, 1'b0);
      6'd1:  w = uw(OP_SUB, R_S,  R_U,  R_T,  C_TS,    1'b0, 1'b0);
      6'd2:  w = uw(OP_MUL, R_T,  R_X,  R_X,  C_STIFF, 1'b0, 1'b0);
      6'd3:  w = uw(OP_SUB, R_S,  R_S,  R_T,  C_TS,    1'b0, 1'b0);
      6'd4:  w = uw(OP_MUL, R_A1, R_S,  R_S,  C_IMASS, 1'b0, 1'b0);
      6'd5:  w = uw(OP_MUL, R_T,  R_A1, R_A1, C_TS,    1'b1, 1'b0);
      6'd6:  w = uw(OP_ADD, R_V2, R_V,  R_T,  C_TS,    1'b0, 1'b0);
      6'd7:  w = uw(OP_MUL, R_T,  R_V,  R_V,  C_TS,    1'b1, 1'b0);
      6'd8:  w = uw(OP_ADD, R_XA, R_X,  R_T,  C_TS,    1'b0, 1'b0);
      // slope 2
      6'd9:  w = uw(OP_MUL, R_T,  R_V2, R_V2, C_DAMP,  1'b0, 1'b0);
      6'd10: w = uw(OP_SUB, R_S,  R_U,  R_T,  C_TS,    1'b0, 1'b0);
      6'd11: w = uw(OP_MUL, R_T,  R_XA, R_XA, C_STIFF, 1'b0, 1'b0);
      6'd12: w = uw(OP_SUB, R_S,  R_S,  R_T,  C_TS,    1'b0, 1'b0);
      6'd13: w = uw(OP_MUL, R_A2, R_S,  R_S,  C_IMASS, 1'b0, 1'b0);
      6'd14: w = uw(OP_MUL, R_T,  R_A2, R_A2, C_TS,    1'b1, 1'b0);
      6'd15: w = uw(OP_ADD, R_V3, R_V,  R_T,  C_TS,    1'b0, 1'b0);
      6'd16: w = uw(OP_MUL, R_T,  R_V2, R_V2, C_TS,    1'b1, 1'b0);
      6'd17: w = uw(OP_ADD, R_XA, R_X,  R_T,  C_TS,    1'b0, 1'b0);
      // slope 3
      6'd18: w = uw(OP_MUL, R_T,  R_V3, R_V3, C_DAMP,  1'b0, 1'b0);
      6'd19: w = uw(OP_SUB, R_S,  R_U,  R_T,  C_TS,    1'b0, 1'b0);
      6'd20: w = uw(OP_MUL, R_T,  R_XA, R_XA, C_STIFF, 1'b0, 1'b0);
      6'd21: w = uw(OP_SUB, R_S,  R_S,  R_T,  C_TS,    1'b0, 1'b0);
      6'd22: w = uw(OP_MUL, R_A3, R_S,  R_S,  C_IMASS, 1'b0, 1'b0);
      6'd23: w = uw(OP_MUL, R_T,  R_A3, R_A3, C_TS,    1'b0, 1'b0);
      6'd24: w = uw(OP_ADD, R_V4, R_V,  R_T,  C_TS,    1'b0, 1'b0);
      6'd25: w = uw(OP_MUL, R_T,  R_V3, R_V3, C_TS,    1'b0, 1'b0);
      6'd26: w = uw(OP_ADD, R_XA, R_X,  R_T,  C_TS,    1'b0, 1'b0);
      // slope 4
      6'd27: w = uw(OP_MUL, R_T,  R_V4, R_V4, C_DAMP,  1'b0, 1'b0);
      6'd28: w = uw(OP_SUB, R_S,  R_U,  R_T,  C_TS,    1'b0, 1'b0);
      6'd29: w = uw(OP_MUL, R_T,  R_XA, R_XA, C_STIFF, 1'b0, 1'b0);
      6'd30: w = uw(OP_SUB, R_S,  R_S,  R_T,  C_TS,    1'b0, 1'b0);
      6'd31: w = uw(OP_MUL, R_A4, R_S,  R_S,  C_IMASS, 1'b0, 1'b0);
      // weighted sums
      6'd32: w = uw(OP_ADD, R_T,  R_V2, R_V2, C_TS,    1'b0, 1'b0);
      6'd33: w = uw(OP_ADD, R_SX, R_V,  R_T,  C_TS,    1'b0, 1'b0);
      6'd34: w = uw(OP_ADD, R_T,  R_V3, R_V3, C_TS,    1'b0, 1'b0);
      6'd35: w = uw(OP_ADD, R_SX, R_SX, R_T,  C_TS,    1'b0, 1'b0);
      6'd36: w = uw(OP_ADD, R_SX, R_SX, R_V4, C_TS,    1'b0, 1'b0);
      6'd37: w = uw(OP_ADD, R_T,  R_A2, R_A2, C_TS,    1'b0, 1'b0);
      6'd38: w = uw(OP_ADD, R_SV, R_A1, R_T,  C_TS,    1'b0, 1'b0);
      6'd39: w = uw(OP_ADD, R_T,  R_A3, R_A3, C_TS,    1'b0, 1'b0);
      6'd40: w = uw(OP_ADD, R_SV, R_SV, R_T,  C_TS,    1'b0, 1'b0);
      6'd41: w = uw(OP_ADD, R_SV, R_SV, R_A4, C_TS,    1'b0, 1'b0);
      // state update
      6'd42: w = uw(OP_MUL, R_T,  R_SX, R_SX, C_TS,    1'b0, 1'b1);
      6'd43: w = uw(OP_ADD, R_X,  R_X,  R_T,  C_TS,    1'b0, 1'b0);
      6'd44: w = uw(OP_MUL, R_T,  R_SV, R_SV, C_TS,    1'b0, 1'b1);
      6'd45: w = uw(OP_ADD, R_V,  R_V,  R_T,  C_TS,    1'b0, 1'b0);
      default: w = uw(OP_END, R_T, R_T,  R_T,  C_TS,    1'b0, 1'b0);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rk4_mass_spring_damper_step.sv
// ----------------------------------------------------------------------------
// rk4_mass_spring_damper_step
// Each transaction runs a microprogram of 20 products, two with a
// divide-by-3 pass, and 26 sums. in_stall holds off the next transaction
// until the sequencer is idle, and all products share the single
// multiplier. A result may wait in the output register while the next runs.
// Reset: state cleared to zero, registers to defaults, sequencer idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rk4_mass_spring_damper_step import rk4msd_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_control_force,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_position_out,
  output logic signed [31:0] out_velocity_out,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  seq_state_t state_r, state_nxt;
  logic [PC_W-1:0] pc_r;
  uword_t          uw_cur;

  logic [31:0] time_step_r;
  logic [30:0] damping_r;
  logic [30:0] stiffness_r;
  logic [30:0] inv_mass_r;

  logic signed [DATA_WIDTH-1:0] pos_r;
  logic signed [DATA_WIDTH-1:0] vel_r;
  logic signed [DATA_WIDTH-1:0] u_r;
  logic signed [DATA_WIDTH-1:0] rf_mem [RF_DEPTH];
  logic signed [DATA_WIDTH-1:0] mem_a_r;
  logic signed [DATA_WIDTH-1:0] mem_b_r;

  logic                         out_valid_r;
  logic signed [31:0]           out_pos_r;
  logic signed [31:0]           out_vel_r;

  logic                         in_acc;
  logic                         mul_start;
  logic                         wr_en;
  logic                         out_load;
  logic                         mul_done;
  logic signed [DATA_WIDTH-1:0] mul_res;
  logic signed [DATA_WIDTH-1:0] opa;
  logic signed [DATA_WIDTH-1:0] opb;
  logic [31:0]                  coef;
  logic [DATA_WIDTH:0]          sum_w;
  logic signed [DATA_WIDTH-1:0] alu_res;
  logic signed [DATA_WIDTH-1:0] wdata;
  logic signed [DATA_WIDTH-1:0] u_dw;
  logic signed [31:0]           pos_o;
  logic signed [31:0]           vel_o;

  assign uw_cur = ucode(pc_r);

  // force into state width, state into port width
  if (DATA_WIDTH < 32) begin : g_usat
    localparam logic signed [31:0] U_MAX = 32'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [31:0] U_MIN = -U_MAX - 32'sd1;
    assign u_dw = (in_control_force > U_MAX) ? DATA_WIDTH'(U_MAX) :
                  (in_control_force < U_MIN) ? DATA_WIDTH'(U_MIN) :
                  DATA_WIDTH'(in_control_force);
  end else begin : g_uext
    assign u_dw = DATA_WIDTH'(in_control_force);
  end

  if (DATA_WIDTH > 32) begin : g_osat
    localparam logic signed [DATA_WIDTH-1:0] O_MAX = DATA_WIDTH'(32'sh7FFF_FFFF);
    localparam logic signed [DATA_WIDTH-1:0] O_MIN = DATA_WIDTH'(32'sh8000_0000);
    assign pos_o = (pos_r > O_MAX) ? 32'sh7FFF_FFFF :
                   (pos_r < O_MIN) ? 32'sh8000_0000 : pos_r[31:0];
    assign vel_o = (vel_r > O_MAX) ? 32'sh7FFF_FFFF :
                   (vel_r < O_MIN) ? 32'sh8000_0000 : vel_r[31:0];
  end else begin : g_oext
    assign pos_o = 32'(pos_r);
    assign vel_o = 32'(vel_r);
  end

  // operand select
  always_comb begin
    unique case (uw_cur.src_a)
      R_X:     opa = pos_r;
      R_V:     opa = vel_r;
      R_U:     opa = u_r;
      default: opa = mem_a_r;
    endcase
    unique case (uw_cur.src_b)
      R_X:     opb = pos_r;
      R_V:     opb = vel_r;
      R_U:     opb = u_r;
      default: opb = mem_b_r;
    endcase
    unique case (uw_cur.coef)
      C_TS:    coef = time_step_r;
      C_DAMP:  coef = {1'b0, damping_r};
      C_STIFF: coef = {1'b0, stiffness_r};
      C_IMASS: coef = {1'b0, inv_mass_r};
      default: coef = time_step_r;
    endcase
  end

  // saturating add / subtract
  always_comb begin
    if (uw_cur.op == OP_SUB) begin
      sum_w = {opa[DATA_WIDTH-1], opa} - {opb[DATA_WIDTH-1], opb};
    end else begin
      sum_w = {opa[DATA_WIDTH-1], opa} + {opb[DATA_WIDTH-1], opb};
    end
    if (sum_w[DATA_WIDTH] != sum_w[DATA_WIDTH-1]) begin
      alu_res = sum_w[DATA_WIDTH] ? SMIN : SMAX;
    end else begin
      alu_res = signed'(sum_w[DATA_WIDTH-1:0]);
    end
  end

  rk4msd_mulq #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mulq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .op_a   (opa),
    .coef   (coef),
    .ctl    (uw_cur.mctl),
    .done   (mul_done),
    .result (mul_res)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SQ_IDLE: if (in_valid) state_nxt = SQ_READ;
      SQ_READ: state_nxt = (uw_cur.op == OP_END) ? SQ_OUT : SQ_EXEC;
      SQ_EXEC: state_nxt = (uw_cur.op == OP_MUL) ? SQ_WAIT : SQ_READ;
      SQ_WAIT: if (mul_done) state_nxt = SQ_READ;
      SQ_OUT:  if (!out_valid_r || !out_stall) state_nxt = SQ_IDLE;
      default: state_nxt = SQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = (state_r != SQ_IDLE);
    in_acc    = (state_r == SQ_IDLE) && in_valid;
    mul_start = (state_r == SQ_EXEC) && (uw_cur.op == OP_MUL);
    wr_en     = ((state_r == SQ_EXEC) && (uw_cur.op != OP_MUL)) ||
                ((state_r == SQ_WAIT) && mul_done);
    out_load  = (state_r == SQ_OUT) && (!out_valid_r || !out_stall);
    wdata     = (state_r == SQ_WAIT) ? mul_res : alu_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SQ_IDLE;
      pc_r        <= '0;
      pos_r       <= '0;
      vel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        pc_r <= '0;
      end else if (wr_en) begin
        pc_r <= pc_r + PC_W'(1);
      end
      if (wr_en && uw_cur.dst == R_X) pos_r <= wdata;
      if (wr_en && uw_cur.dst == R_V) vel_r <= wdata;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= 32'd655;
      damping_r   <= 31'd65536;
      stiffness_r <= 31'd65536;
      inv_mass_r  <= 31'd65536;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TIME_STEP:    time_step_r <= cfg_wdata;
        CFG_DAMPING:      damping_r   <= cfg_wdata[30:0];
        CFG_STIFFNESS:    stiffness_r <= cfg_wdata[30:0];
        CFG_INVERSE_MASS: inv_mass_r  <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // scratch register file
  always_ff @(posedge clk) begin
    if (wr_en) rf_mem[uw_cur.dst] <= wdata;
    mem_a_r <= rf_mem[uw_cur.src_a];
    mem_b_r <= rf_mem[uw_cur.src_b];
  end

  always_ff @(posedge clk) begin
    if (in_acc) u_r <= u_dw;
    if (out_load) begin
      out_pos_r <= pos_o;
      out_vel_r <= vel_o;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_position_out = out_pos_r;
  assign out_velocity_out = out_vel_r;

endmodule

`default_nettype wire

FILE: rtl/core/rk4msd_mulq.sv
// ----------------------------------------------------------------------------
// rk4msd_mulq
// Multi-cycle scaled multiplier: floor(a * c / (d * 2^sh)) saturated to
// DATA_WIDTH bits, d = 1, 2 or 6. 32x32 partial products, radix-256 divide by 3.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rk4msd_mulq import rk4msd_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] op_a,
  input  logic [31:0]                  coef,
  input  mul_ctl_t                     ctl,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] result
);

  localparam int NL    = (DATA_WIDTH + 31) / 32;
  localparam int MW    = NL * 32;
  localparam int PW    = MW + 32;
  localparam int ND    = PW / 8;
  localparam int CNT_W = $clog2(ND);

  localparam logic [PW-1:0] LIM_NEG = PW'(1) << (DATA_WIDTH - 1);
  localparam logic [PW-1:0] LIM_POS = LIM_NEG - PW'(1);

  mul_state_t state_r, state_nxt;

  logic [MW-1:0]         m_r;
  logic [31:0]           c_r;
  logic                  neg_r;
  mul_ctl_t              ctl_r;
  logic [PW-1:0]         acc_r;
  logic [1:0]            rem3_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DATA_WIDTH-1:0] q_r;
  logic                  inc_r;

  logic [DATA_WIDTH-1:0] a_mag;
  logic [63:0]           pp;
  logic [PW-1:0]         mul_acc;
  logic [7:0]            qd;
  logic [1:0]            div_rem;
  logic [PW-1:0]         div_acc;
  logic [PW-1:0]         qmag;
  logic [PW-1:0]         lim;
  logic                  low_nz;
  logic                  rem_any;
  logic [DATA_WIDTH-1:0] mag;
  logic                  mul_last;
  logic                  div_last;

  assign a_mag    = op_a[DATA_WIDTH-1] ? (unsigned'(~op_a) + DATA_WIDTH'(1)) : unsigned'(op_a);
  assign pp       = 64'(m_r[MW-1 -: 32]) * 64'(c_r);
  assign mul_acc  = (acc_r << 32) + PW'(pp);
  assign mul_last = (cnt_r == CNT_W'(NL - 1));
  assign div_last = (cnt_r == CNT_W'(ND - 1));

  // eight radix-2 steps of division by three, MSB first
  always_comb begin
    logic [2:0] t;
    logic [1:0] r;
    r  = rem3_r;
    qd = '0;
    for (int i = 0; i < 8; i++) begin
      t = {r, acc_r[PW-1-i]};
      if (t >= 3'd3) begin
        qd[7-i] = 1'b1;
        r       = 2'(t - 3'd3);
      end else begin
        r       = t[1:0];
      end
    end
    div_rem = r;
  end

  assign div_acc = {acc_r[PW-9:0], qd};

  always_comb begin
    if (ctl_r.half || ctl_r.div6) begin
      qmag   = acc_r >> (FRAC_BITS + 1);
      low_nz = |acc_r[FRAC_BITS:0];
    end else begin
      qmag   = acc_r >> FRAC_BITS;
      low_nz = |acc_r[FRAC_BITS-1:0];
    end
  end

  assign lim     = neg_r ? LIM_NEG : LIM_POS;
  assign rem_any = (rem3_r != 2'd0) || low_nz;
  assign mag     = q_r + DATA_WIDTH'(inc_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MS_IDLE: if (start) state_nxt = MS_MUL;
      MS_MUL: begin
        if (mul_last) state_nxt = ctl_r.div6 ? MS_DIV : MS_FIN;
      end
      MS_DIV: if (div_last) state_nxt = MS_FIN;
      MS_FIN: state_nxt = MS_NEG;
      MS_NEG: state_nxt = MS_IDLE;
      default: state_nxt = MS_IDLE;
    endcase
  end

  always_comb begin
    done   = (state_r == MS_NEG);
    result = neg_r ? signed'(~mag + DATA_WIDTH'(1)) : signed'(mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MS_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == MS_MUL && mul_last) || (state_r == MS_DIV && div_last) ||
          state_r == MS_IDLE) begin
        cnt_r <= '0;
      end else if (state_r == MS_MUL || state_r == MS_DIV) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      MS_IDLE: begin
        if (start) begin
          m_r    <= MW'(a_mag);
          c_r    <= coef;
          neg_r  <= op_a[DATA_WIDTH-1];
          ctl_r  <= ctl;
          acc_r  <= '0;
          rem3_r <= 2'd0;
        end
      end
      MS_MUL: begin
        acc_r <= mul_acc;
        m_r   <= m_r << 32;
      end
      MS_DIV: begin
        acc_r  <= div_acc;
        rem3_r <= div_rem;
      end
      MS_FIN: begin
        q_r   <= (qmag > lim) ? lim[DATA_WIDTH-1:0] : qmag[DATA_WIDTH-1:0];
        inc_r <= neg_r && rem_any && (qmag < lim);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
